// ===== rtl/core/quicksort_key_tag_sorter_unit_macros.svh =====
// Assertion macros for the quicksort sorter RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef QUICKSORT_KEY_TAG_SORTER_UNIT_MACROS_SVH
`define QUICKSORT_KEY_TAG_SORTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/qs_pkg.sv =====
// Package for the quicksort key/tag sorter: word types, sequencer states
// and default parameter values. No dependencies.
package qs_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int TAG_W        = 8;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last_in;
    } in_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             last_out;
    } out_word_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctl_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_START,
        ST_POP,
        ST_POPW,
        ST_PIV,
        ST_L_RD,
        ST_L_CHK,
        ST_R_RD,
        ST_R_CHK,
        ST_SWAP,
        ST_PUSH_HI,
        ST_PUSH_LO,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

endpackage

// ===== rtl/core/qs_stack.sv =====
// Range stack of the quicksort sequencer: a small memory of [from,to] pairs
// with a level counter. Depends on qs_pkg.
module qs_stack
    import qs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  stk_ctl_t                 ctl,
    input  logic [$clog2(DEPTH)-1:0] push_from,
    input  logic [$clog2(DEPTH)-1:0] push_to,
    output logic [$clog2(DEPTH)-1:0] top_from,
    output logic [$clog2(DEPTH)-1:0] top_to,
    output logic                     empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [2*AW-1:0] stk_mem [DEPTH];
    logic [2*AW-1:0] rd_reg;
    logic [CW-1:0]   level_reg;
    logic [CW-1:0]   level_next;
    logic [CW-1:0]   pop_lvl;

    assign pop_lvl = level_reg - CW'(1);

    always_comb
    begin
        level_next = level_reg;
        if (ctl.push)
        begin
            level_next = level_reg + CW'(1);
        end
        else if (ctl.pop)
        begin
            level_next = pop_lvl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    // Pop reads the entry below the current level; data is valid next cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            stk_mem[level_reg[AW-1:0]] <= {push_from, push_to};
        end
        rd_reg <= stk_mem[pop_lvl[AW-1:0]];
    end

    assign top_from = rd_reg[2*AW-1:AW];
    assign top_to   = rd_reg[AW-1:0];
    assign empty    = (level_reg == '0);

endmodule

// ===== rtl/core/quicksort_key_tag_sorter_unit.sv =====
// Top level of the quicksort key/tag sorter: key/tag store, sequencer and
// output register. Depends on qs_pkg, qs_stack and the assertion macros.

// Words (a key and a tag) are loaded one per cycle into a local store of
// DEPTH entries; words beyond DEPTH are dropped, but a dropped word marked
// last_in still starts the sort. The word marked last_in starts an in-place
// quicksort (first element as pivot, Hoare two-index scan, explicit range
// stack), after which every stored word leaves in ascending key order, the
// final one with last_out set, and the block returns to loading with an
// empty store. The sort uses two key comparisons with the pivot (less-than
// for the left scan, greater-than for the right) and a store with one write
// port and one registered read port: each key a scan visits is read, then
// checked; a swap writes its two words in turn; each partition adds stack
// and pivot work. Each output word is read, loaded into the output register
// and held until the sink takes it. No word is accepted between the last_in
// word and the hand-off of the final result.
`include "quicksort_key_tag_sorter_unit_macros.svh"

module quicksort_key_tag_sorter_unit
    import qs_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       from_reg, from_next;
    logic [AW-1:0]       to_reg, to_next;
    logic [AW-1:0]       left_reg, left_next;
    logic [AW-1:0]       right_reg, right_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [KEY_BITS-1:0] pivot_reg, pivot_next;
    logic [KEY_BITS-1:0] lkey_reg, lkey_next;
    logic [TAG_W-1:0]    ltag_reg, ltag_next;
    out_word_t           result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    // Store: one write port and one registered read port.
    logic [KEY_BITS-1:0] key_mem [DEPTH];
    logic [TAG_W-1:0]    tag_mem [DEPTH];
    logic [KEY_BITS-1:0] rkey_reg;
    logic [TAG_W-1:0]    rtag_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [KEY_BITS-1:0] mem_wkey;
    logic [TAG_W-1:0]    mem_wtag;
    logic [AW-1:0]       mem_raddr;

    // Range stack control.
    stk_ctl_t      stk_ctl;
    logic [AW-1:0] stk_from, stk_to;
    logic [AW-1:0] stk_top_from, stk_top_to;
    logic          stk_empty;

    // Two key comparators: the fetched key against the pivot.
    logic key_lt, key_gt;
    logic accept_in;
    logic [CW-1:0] part_up;

    assign key_lt    = (rkey_reg < pivot_reg);
    assign key_gt    = (rkey_reg > pivot_reg);
    assign accept_in = item_valid && !item_stall;
    assign part_up   = CW'(right_reg) + CW'(1);

    assign item_stall   = (state_reg != ST_LOAD);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    qs_stack #(
        .DEPTH(DEPTH)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (stk_ctl),
        .push_from(stk_from),
        .push_to  (stk_to),
        .top_from (stk_top_from),
        .top_to   (stk_top_to),
        .empty    (stk_empty)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wkey;
            tag_mem[mem_waddr] <= mem_wtag;
        end
        rkey_reg <= key_mem[mem_raddr];
        rtag_reg <= tag_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            fill_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg   <= from_next;
        to_reg     <= to_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        idx_reg    <= idx_next;
        pivot_reg  <= pivot_next;
        lkey_reg   <= lkey_next;
        ltag_reg   <= ltag_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        from_next         = from_reg;
        to_next           = to_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        idx_next          = idx_reg;
        pivot_next        = pivot_reg;
        lkey_next         = lkey_reg;
        ltag_next         = ltag_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        mem_we            = 1'b0;
        mem_waddr         = fill_reg[AW-1:0];
        mem_wkey          = KEY_BITS'(item.key);
        mem_wtag          = item.tag;
        mem_raddr         = left_reg;
        stk_ctl           = '0;
        stk_from          = from_reg;
        stk_to            = to_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept_in)
                begin
                    if (fill_reg < CW'(DEPTH))
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end
                    if (item.last_in)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                idx_next = '0;
                if (fill_reg > CW'(1))
                begin
                    stk_ctl.push = 1'b1;
                    stk_from     = '0;
                    stk_to       = AW'(fill_reg - CW'(1));
                    state_next   = ST_POP;
                end
                else
                begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_POP:
            begin
                if (stk_empty)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    stk_ctl.pop = 1'b1;
                    state_next  = ST_POPW;
                end
            end
            ST_POPW:
            begin
                from_next  = stk_top_from;
                to_next    = stk_top_to;
                left_next  = stk_top_from;
                right_next = stk_top_to;
                mem_raddr  = stk_top_from;
                state_next = ST_PIV;
            end
            ST_PIV:
            begin
                pivot_next = rkey_reg;
                state_next = ST_L_RD;
            end
            ST_L_RD:
            begin
                mem_raddr  = left_reg;
                state_next = ST_L_CHK;
            end
            ST_L_CHK:
            begin
                if ((left_reg < to_reg) && key_lt)
                begin
                    left_next  = left_reg + AW'(1);
                    state_next = ST_L_RD;
                end
                else
                begin
                    lkey_next  = rkey_reg;
                    ltag_next  = rtag_reg;
                    state_next = ST_R_RD;
                end
            end
            ST_R_RD:
            begin
                mem_raddr  = right_reg;
                state_next = ST_R_CHK;
            end
            ST_R_CHK:
            begin
                if ((right_reg > from_reg) && key_gt)
                begin
                    right_next = right_reg - AW'(1);
                    state_next = ST_R_RD;
                end
                else if (left_reg >= right_reg)
                begin
                    state_next = ST_PUSH_HI;
                end
                else
                begin
                    // First half of the swap: the right word moves left.
                    mem_we     = 1'b1;
                    mem_waddr  = left_reg;
                    mem_wkey   = rkey_reg;
                    mem_wtag   = rtag_reg;
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = right_reg;
                mem_wkey   = lkey_reg;
                mem_wtag   = ltag_reg;
                left_next  = left_reg + AW'(1);
                right_next = right_reg - AW'(1);
                state_next = ST_L_RD;
            end
            ST_PUSH_HI:
            begin
                // The split point sits in right_reg; the upper part goes
                // on the stack first so the lower part is sorted first.
                if (part_up < CW'(to_reg))
                begin
                    stk_ctl.push = 1'b1;
                    stk_from     = AW'(part_up);
                    stk_to       = to_reg;
                end
                state_next = ST_PUSH_LO;
            end
            ST_PUSH_LO:
            begin
                if (from_reg < right_reg)
                begin
                    stk_ctl.push = 1'b1;
                    stk_from     = from_reg;
                    stk_to       = right_reg;
                end
                state_next = ST_POP;
            end
            ST_OUT_RD:
            begin
                mem_raddr  = idx_reg;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                result_next.sorted_key = KEY_W'(rkey_reg);
                result_next.sorted_tag = rtag_reg;
                result_next.last_out   = (CW'(idx_reg) == (fill_reg - CW'(1)));
                result_valid_next      = 1'b1;
                state_next             = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (!result_stall)
                begin
                    result_valid_next = 1'b0;
                    if (result_reg.last_out)
                    begin
                        fill_next  = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    `QS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= CW'(DEPTH), "fill count beyond depth")
    `QS_ASSERT_IMPL(a_scan_window, state_reg == ST_L_CHK,
                    (left_reg >= from_reg) && (left_reg <= to_reg), "left index outside range")
    `QS_ASSERT_IMPL(a_result_state, result_valid_reg, state_reg == ST_OUT_WAIT,
                    "result shown outside output state")
    `QS_ASSERT_NEXT(a_back_to_load, result_valid && !result_stall && result.last_out,
                    (state_reg == ST_LOAD) && (fill_reg == '0), "no return to loading")

endmodule

// ===== sim/quicksort_key_tag_sorter_unit_tb.sv =====
// Testbench for the quicksort key/tag sorter: loads word sets, predicts the sorted output
// with its own quicksort, and checks every result word. Depends on qs_pkg and the sorter RTL.
`timescale 1ns / 1ps

module quicksort_key_tag_sorter_unit_tb;
    import qs_pkg::*;

    localparam int DEPTH     = 64;
    localparam int MAX_CYC   = 2000000;

    // Scoreboard: keeps its own copy of the store, sorts it when a set closes
    // and queues the sorted words for comparison with the block's output.
    class sort_scoreboard;
        logic [KEY_W-1:0] keys[DEPTH];
        logic [TAG_W-1:0] tags[DEPTH];
        int fill;
        out_word_t sorted_q[$];
        int mismatches;
        int words_checked;
        int sets_done;

        function void swap_pair(int a, int b);
            logic [KEY_W-1:0] k;
            logic [TAG_W-1:0] t;
            k = keys[a];
            t = tags[a];
            keys[a] = keys[b];
            tags[a] = tags[b];
            keys[b] = k;
            tags[b] = t;
        endfunction

        // Hoare scan with the first element as pivot; returns the split index.
        function int hoare_split(int lo, int hi);
            logic [KEY_W-1:0] pivot;
            int l;
            int r;
            pivot = keys[lo];
            l = lo - 1;
            r = hi + 1;
            forever
            begin
                do l++; while (l < hi && keys[l] < pivot);
                do r--; while (r > lo && keys[r] > pivot);
                if (l >= r)
                    return r;
                swap_pair(l, r);
            end
        endfunction

        function void run_sort(int n);
            int lo_s[2*DEPTH+2];
            int hi_s[2*DEPTH+2];
            int lvl;
            int lo;
            int hi;
            int p;
            lvl = 0;
            if (n > 1)
            begin
                lo_s[0] = 0;
                hi_s[0] = n - 1;
                lvl = 1;
            end
            while (lvl > 0)
            begin
                lvl--;
                lo = lo_s[lvl];
                hi = hi_s[lvl];
                p = hoare_split(lo, hi);
                // The upper range is stacked first so the lower one is sorted next.
                if (p + 1 < hi)
                begin
                    lo_s[lvl] = p + 1;
                    hi_s[lvl] = hi;
                    lvl++;
                end
                if (lo < p)
                begin
                    lo_s[lvl] = lo;
                    hi_s[lvl] = p;
                    lvl++;
                end
            end
        endfunction

        function void note_input(in_word_t w);
            out_word_t o;
            if (fill < DEPTH)
            begin
                keys[fill] = w.key;
                tags[fill] = w.tag;
                fill++;
            end
            if (w.last_in)
            begin
                run_sort(fill);
                for (int i = 0; i < fill; i++)
                begin
                    o.sorted_key = keys[i];
                    o.sorted_tag = tags[i];
                    o.last_out   = (i == fill - 1);
                    sorted_q.push_back(o);
                end
                fill = 0;
                sets_done++;
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp_w;
            if (sorted_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %h", got);
                return;
            end
            exp_w = sorted_q.pop_front();
            words_checked++;
            if (got !== exp_w)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: key exp %h got %h, tag exp %h got %h, last exp %b got %b",
                             exp_w.sorted_key, got.sorted_key, exp_w.sorted_tag,
                             got.sorted_tag, exp_w.last_out, got.last_out);
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_word_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_word_t result;

    sort_scoreboard sb;
    int send_idle_pct = 27;
    int recv_idle_pct = 48;
    int items_sent = 0;
    int cycles = 0;

    quicksort_key_tag_sorter_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: ends the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stall, check each accepted word at the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Present one word and hold it until the block accepts it. Random idle
    // cycles before the word put gaps between the input words. Valid stays
    // high after an accept only until the next word or an idle cycle follows.
    task automatic send_word(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{key: k, tag: t, last_in: lst};
        do @(posedge clk); while (item_stall);
        sb.note_input('{key: k, tag: t, last_in: lst});
        items_sent++;
    endtask

    // Load a whole set of n words with random content; keys are drawn from a
    // narrow range now and then so that duplicates are common.
    task automatic send_set(int n);
        logic [KEY_W-1:0] k;
        int narrow;
        narrow = $urandom_range(2);
        for (int i = 0; i < n; i++)
        begin
            k = (narrow == 0) ? KEY_W'($urandom_range(3)) : KEY_W'($urandom);
            send_word(k, TAG_W'($urandom), i == n - 1);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (sb.sorted_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(int target);
        int n;
        while (items_sent < target)
        begin
            // Mostly small sets, a full or overfull set now and then.
            case ($urandom_range(9))
                0:       n = $urandom_range(DEPTH + 6, DEPTH);
                1, 2:    n = 1;
                default: n = $urandom_range(12, 2);
            endcase
            send_set(n);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a single word, extremes of the fields, all equal keys,
        // a reversed set, and a store that overflows by one word.
        send_word(16'hFFFF, 8'hFF, 1'b1);
        send_word(16'h0000, 8'h00, 1'b1);
        send_word(16'hFFFF, 8'h01, 1'b0);
        send_word(16'h0000, 8'h02, 1'b0);
        send_word(16'h8000, 8'h80, 1'b0);
        send_word(16'h7FFF, 8'h7F, 1'b1);
        for (int i = 0; i < 4; i++)
            send_word(16'h1234, 8'(i), i == 3);
        for (int i = 0; i < 5; i++)
            send_word(16'(50 - i), 8'(i + 16), i == 4);
        // Pause until every expected word has come back.
        drain_results();
        for (int i = 0; i < DEPTH + 1; i++)
            send_word(16'($urandom), 8'($urandom), i == DEPTH);

        random_phase(130);
        send_idle_pct = 48;
        recv_idle_pct = 27;
        random_phase(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(365);

        drain_results();
        $display("Ran %0d input words in %0d sets; %0d sorted words checked.",
                 items_sent, sb.sets_done, sb.words_checked);
        if (sb.mismatches == 0 && sb.sorted_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/qs_pkg.sv
rtl/core/qs_stack.sv
rtl/core/quicksort_key_tag_sorter_unit.sv
sim/quicksort_key_tag_sorter_unit_tb.sv
